>>> rtl/tffs_pkg.sv
// shared types, codes and constants for the tcp flow flag statistics block
package tffs_pkg;

    localparam int COUNTER_WIDTH_DEFAULT = 32;
    localparam int NUM_EVENTS            = 15;
    localparam int QUEUE_DEPTH           = 2;

    // command codes on the input word
    localparam logic [1:0] CMD_PACKET = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // direction codes
    localparam logic [1:0] DIR_FORWARD  = 2'd0;
    localparam logic [1:0] DIR_BACKWARD = 2'd1;

    // tcp flag bit positions
    localparam int FLAG_SYN = 0;
    localparam int FLAG_ACK = 1;
    localparam int FLAG_FIN = 2;
    localparam int FLAG_RST = 3;
    localparam int FLAG_PSH = 4;
    localparam int FLAG_URG = 5;

    // counter numbers
    localparam int EV_PACKETS       = 0;
    localparam int EV_SYN           = 1;
    localparam int EV_SYN_ONLY      = 2;
    localparam int EV_FIN           = 3;
    localparam int EV_RST           = 4;
    localparam int EV_PSH           = 5;
    localparam int EV_ACK           = 6;
    localparam int EV_PURE_ACK      = 7;
    localparam int EV_URG           = 8;
    localparam int EV_SYN_ACK       = 9;
    localparam int EV_PAYLOAD       = 10;
    localparam int EV_WIN_UPDATE    = 11;
    localparam int EV_RETRANS       = 12;
    localparam int EV_ZERO_WIN      = 13;
    localparam int EV_RST_INTERVALS = 14;

    typedef enum logic [1:0] {
        OP_PACKET,
        OP_READ,
        OP_CLEAR,
        OP_IGNORE
    } t_op;

    // classified word handed from the front to the back
    typedef struct packed {
        t_op                    op;
        logic [NUM_EVENTS-1:0]  events;
        logic                   win_cand;
        logic                   has_payload;
        logic                   rst;
        logic [15:0]            window_size;
        logic [1:0]             dir;
        logic [31:0]            seq;
        logic [63:0]            ts;
        logic [3:0]             sel;
    } t_work;

endpackage

>>> rtl/tffs_front.sv
// front part: decodes the command and the flag events of each accepted word
module tffs_front (
    input  logic [1:0]     i_cmd,
    input  logic [5:0]     i_tcp_flags,
    input  logic [15:0]    i_payload_length,
    input  logic [15:0]    i_window_size,
    input  logic [1:0]     i_flow_direction,
    input  logic [31:0]    i_sequence_number,
    input  logic [63:0]    i_timestamp_us,
    input  logic [3:0]     i_counter_select,
    output tffs_pkg::t_work o_work
);

    logic syn, ack, fin, rst, psh, urg;
    logic has_payload;
    logic is_pkt;
    logic [tffs_pkg::NUM_EVENTS-1:0] events;

    assign syn = i_tcp_flags[tffs_pkg::FLAG_SYN];
    assign ack = i_tcp_flags[tffs_pkg::FLAG_ACK];
    assign fin = i_tcp_flags[tffs_pkg::FLAG_FIN];
    assign rst = i_tcp_flags[tffs_pkg::FLAG_RST];
    assign psh = i_tcp_flags[tffs_pkg::FLAG_PSH];
    assign urg = i_tcp_flags[tffs_pkg::FLAG_URG];
    assign has_payload = (i_payload_length != 16'd0);
    assign is_pkt = (i_cmd == tffs_pkg::CMD_PACKET);

    always_comb begin
        events = '0;
        events[tffs_pkg::EV_PACKETS]  = 1'b1;
        events[tffs_pkg::EV_SYN]      = syn;
        events[tffs_pkg::EV_SYN_ONLY] = syn && !ack;
        events[tffs_pkg::EV_FIN]      = fin;
        events[tffs_pkg::EV_RST]      = rst;
        events[tffs_pkg::EV_PSH]      = psh;
        events[tffs_pkg::EV_ACK]      = ack;
        events[tffs_pkg::EV_PURE_ACK] = ack && !syn && !fin && !rst && !psh && !has_payload;
        events[tffs_pkg::EV_URG]      = urg;
        events[tffs_pkg::EV_SYN_ACK]  = syn && ack;
        events[tffs_pkg::EV_PAYLOAD]  = has_payload;
        events[tffs_pkg::EV_ZERO_WIN] = (i_window_size == 16'd0);
        // window update, retransmission and rst interval need flow state
        if (!is_pkt) begin
            events = '0;
        end
    end

    always_comb begin
        unique case (i_cmd)
            tffs_pkg::CMD_PACKET: o_work.op = tffs_pkg::OP_PACKET;
            tffs_pkg::CMD_READ:   o_work.op = tffs_pkg::OP_READ;
            tffs_pkg::CMD_CLEAR:  o_work.op = tffs_pkg::OP_CLEAR;
            default:              o_work.op = tffs_pkg::OP_IGNORE;
        endcase
        o_work.events      = events;
        o_work.win_cand    = ack && !has_payload;
        o_work.has_payload = has_payload;
        o_work.rst         = rst;
        o_work.window_size = i_window_size;
        o_work.dir         = i_flow_direction;
        o_work.seq         = i_sequence_number;
        o_work.ts          = i_timestamp_us;
        o_work.sel         = i_counter_select;
    end

endmodule

>>> rtl/tffs_queue.sv
// short first-in first-out queue between the front and the back
module tffs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tffs_pkg::t_work i_work,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output tffs_pkg::t_work o_work
);

    localparam int DEPTH = tffs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tffs_pkg::t_work r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_work  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

endmodule

>>> rtl/tffs_back.sv
// back part: flow state, saturating counters and the result register
module tffs_back #(
    parameter int COUNTER_WIDTH = tffs_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_work_valid,
    input  tffs_pkg::t_work i_work,
    output logic            o_pop,
    input  logic            i_stall,
    output logic            o_valid,
    output logic [63:0]     o_counter_value,
    output logic            o_retransmission_seen,
    output logic            o_window_update_seen,
    output logic            o_pure_ack_seen,
    output logic            o_rst_interval_added
);

    localparam int NEV = tffs_pkg::NUM_EVENTS;

    logic [COUNTER_WIDTH-1:0] r_cnt [NEV];
    logic [COUNTER_WIDTH-1:0] n_cnt [NEV];
    logic [63:0] r_total, n_total;
    logic [63:0] r_prev_rst, n_prev_rst;
    logic [15:0] r_prev_win, n_prev_win;
    logic        r_win_seen, n_win_seen;
    logic [31:0] r_prev_fwd, n_prev_fwd;
    logic        r_fwd_seen, n_fwd_seen;
    logic [31:0] r_prev_bwd, n_prev_bwd;
    logic        r_bwd_seen, n_bwd_seen;

    logic        r_valid, n_valid;
    logic [63:0] r_value, n_value;
    logic        r_retrans, n_retrans;
    logic        r_winupd, n_winupd;
    logic        r_pure, n_pure;
    logic        r_rstadd, n_rstadd;

    logic           go;
    logic           is_pkt;
    logic           rst_hit;
    logic           win_upd;
    logic           fwd_hit;
    logic           bwd_hit;
    logic           retrans;
    logic [63:0]    delta;
    logic [64:0]    sum;
    logic [63:0]    read_value;
    logic [NEV-1:0] events;

    assign go     = i_work_valid && (!r_valid || !i_stall);
    assign o_pop  = go;
    assign is_pkt = (i_work.op == tffs_pkg::OP_PACKET);

    // rst interval: zero previous time means no earlier rst
    assign rst_hit = is_pkt && i_work.rst && (r_prev_rst != 64'd0) && (i_work.ts > r_prev_rst);
    assign delta   = i_work.ts - r_prev_rst;
    assign sum     = {1'b0, r_total} + {1'b0, delta};

    assign win_upd = is_pkt && r_win_seen && i_work.win_cand
                  && (i_work.window_size != r_prev_win);
    assign fwd_hit = is_pkt && i_work.has_payload && (i_work.dir == tffs_pkg::DIR_FORWARD)
                  && r_fwd_seen && (i_work.seq <= r_prev_fwd);
    assign bwd_hit = is_pkt && i_work.has_payload && (i_work.dir == tffs_pkg::DIR_BACKWARD)
                  && r_bwd_seen && (i_work.seq <= r_prev_bwd);
    assign retrans = fwd_hit || bwd_hit;

    always_comb begin
        events = i_work.events;
        events[tffs_pkg::EV_WIN_UPDATE]    = win_upd;
        events[tffs_pkg::EV_RETRANS]       = retrans;
        events[tffs_pkg::EV_RST_INTERVALS] = rst_hit;
    end

    // counter fifteen is the 64-bit interval sum
    always_comb begin
        if (i_work.sel < 4'(NEV)) begin
            read_value = 64'(r_cnt[i_work.sel]);
        end else begin
            read_value = r_total;
        end
    end

    always_comb begin
        n_cnt      = r_cnt;
        n_total    = r_total;
        n_prev_rst = r_prev_rst;
        n_prev_win = r_prev_win;
        n_win_seen = r_win_seen;
        n_prev_fwd = r_prev_fwd;
        n_fwd_seen = r_fwd_seen;
        n_prev_bwd = r_prev_bwd;
        n_bwd_seen = r_bwd_seen;

        n_value   = r_value;
        n_retrans = r_retrans;
        n_winupd  = r_winupd;
        n_pure    = r_pure;
        n_rstadd  = r_rstadd;
        n_valid   = r_valid && i_stall;

        if (go) begin
            n_valid   = 1'b1;
            n_value   = 64'd0;
            n_retrans = 1'b0;
            n_winupd  = 1'b0;
            n_pure    = 1'b0;
            n_rstadd  = 1'b0;
            unique case (i_work.op)
                tffs_pkg::OP_PACKET: begin
                    for (int i = 0; i < NEV; i++) begin
                        if (events[i] && (r_cnt[i] != '1)) begin
                            n_cnt[i] = r_cnt[i] + COUNTER_WIDTH'(1);
                        end
                    end
                    if (rst_hit) begin
                        n_total = sum[64] ? '1 : sum[63:0];
                    end
                    if (i_work.rst) begin
                        n_prev_rst = i_work.ts;
                    end
                    n_prev_win = i_work.window_size;
                    n_win_seen = 1'b1;
                    if (i_work.has_payload && (i_work.dir == tffs_pkg::DIR_FORWARD)) begin
                        n_prev_fwd = i_work.seq;
                        n_fwd_seen = 1'b1;
                    end
                    if (i_work.has_payload && (i_work.dir == tffs_pkg::DIR_BACKWARD)) begin
                        n_prev_bwd = i_work.seq;
                        n_bwd_seen = 1'b1;
                    end
                    n_retrans = retrans;
                    n_winupd  = win_upd;
                    n_pure    = i_work.events[tffs_pkg::EV_PURE_ACK];
                    n_rstadd  = rst_hit;
                end
                tffs_pkg::OP_READ: begin
                    n_value = read_value;
                end
                tffs_pkg::OP_CLEAR: begin
                    for (int i = 0; i < NEV; i++) begin
                        n_cnt[i] = '0;
                    end
                    n_total    = '0;
                    n_prev_rst = '0;
                    n_prev_win = '0;
                    n_win_seen = 1'b0;
                    n_prev_fwd = '0;
                    n_fwd_seen = 1'b0;
                    n_prev_bwd = '0;
                    n_bwd_seen = 1'b0;
                end
                tffs_pkg::OP_IGNORE: begin
                    n_value = 64'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NEV; i++) begin
                r_cnt[i] <= '0;
            end
            r_total    <= '0;
            r_prev_rst <= '0;
            r_prev_win <= '0;
            r_win_seen <= 1'b0;
            r_prev_fwd <= '0;
            r_fwd_seen <= 1'b0;
            r_prev_bwd <= '0;
            r_bwd_seen <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_total    <= n_total;
            r_prev_rst <= n_prev_rst;
            r_prev_win <= n_prev_win;
            r_win_seen <= n_win_seen;
            r_prev_fwd <= n_prev_fwd;
            r_fwd_seen <= n_fwd_seen;
            r_prev_bwd <= n_prev_bwd;
            r_bwd_seen <= n_bwd_seen;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_retrans <= n_retrans;
        r_winupd  <= n_winupd;
        r_pure    <= n_pure;
        r_rstadd  <= n_rstadd;
    end

    assign o_valid               = r_valid;
    assign o_counter_value       = r_value;
    assign o_retransmission_seen = r_retrans;
    assign o_window_update_seen  = r_winupd;
    assign o_pure_ack_seen       = r_pure;
    assign o_rst_interval_added  = r_rstadd;

endmodule

>>> rtl/tcp_flow_flag_statistics.sv
// Per-flow TCP flag and event statistics. Each accepted word is a packet update, a counter
// read, a clear or an ignored command, and each gives exactly one result word. The block
// takes one word per cycle while o_stall is low: the front decodes the command and the flags,
// a two-entry queue holds decoded words, and the back updates all fifteen saturating
// counters, the 64-bit rst interval sum and the flow state of one word and registers its
// result word. Counters are COUNTER_WIDTH bits wide and read back zero-extended to 64 bits;
// counter fifteen is the interval sum. The input stalls only when the queue is full, which
// happens only while the output is held.
module tcp_flow_flag_statistics #(
    parameter int COUNTER_WIDTH = tffs_pkg::COUNTER_WIDTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_tcp_flags,
    input  logic [15:0] i_payload_length,
    input  logic [15:0] i_window_size,
    input  logic [1:0]  i_flow_direction,
    input  logic [31:0] i_sequence_number,
    input  logic [63:0] i_timestamp_us,
    input  logic [3:0]  i_counter_select,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_counter_value,
    output logic        o_retransmission_seen,
    output logic        o_window_update_seen,
    output logic        o_pure_ack_seen,
    output logic        o_rst_interval_added
);

    tffs_pkg::t_work front_work;
    tffs_pkg::t_work queue_work;
    logic            queue_full;
    logic            queue_valid;
    logic            queue_pop;
    logic            push;

    assign o_stall = queue_full;
    assign push    = i_valid && !queue_full;

    tffs_front u_front (
        .i_cmd             (i_cmd),
        .i_tcp_flags       (i_tcp_flags),
        .i_payload_length  (i_payload_length),
        .i_window_size     (i_window_size),
        .i_flow_direction  (i_flow_direction),
        .i_sequence_number (i_sequence_number),
        .i_timestamp_us    (i_timestamp_us),
        .i_counter_select  (i_counter_select),
        .o_work            (front_work)
    );

    tffs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_work  (queue_work)
    );

    tffs_back #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_work_valid          (queue_valid),
        .i_work                (queue_work),
        .o_pop                 (queue_pop),
        .i_stall               (i_stall),
        .o_valid               (o_valid),
        .o_counter_value       (o_counter_value),
        .o_retransmission_seen (o_retransmission_seen),
        .o_window_update_seen  (o_window_update_seen),
        .o_pure_ack_seen       (o_pure_ack_seen),
        .o_rst_interval_added  (o_rst_interval_added)
    );

endmodule

>>> rtl/tffs_checker.sv
// port-level checks for the tcp flow flag statistics block, bound to the top level
module tffs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_stall,
    input logic        o_valid,
    input logic [63:0] o_counter_value,
    input logic        o_retransmission_seen,
    input logic        o_window_update_seen,
    input logic        o_pure_ack_seen,
    input logic        o_rst_interval_added
);

    // no result survives a reset
    a_reset_empties_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a held result keeps its word
    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_counter_value))
        else $error("stalled result changed");

    // only a read carries a counter value, and a read carries no event flags
    a_read_has_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_counter_value != 64'd0) |->
            !o_retransmission_seen && !o_window_update_seen
            && !o_pure_ack_seen && !o_rst_interval_added)
        else $error("event flags on a read result");

    // retransmission needs payload, pure ack and window update need none
    a_payload_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_retransmission_seen |-> !o_pure_ack_seen && !o_window_update_seen)
        else $error("retransmission together with a no-payload event");

endmodule

bind tcp_flow_flag_statistics tffs_checker u_tffs_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_stall               (i_stall),
    .o_valid               (o_valid),
    .o_counter_value       (o_counter_value),
    .o_retransmission_seen (o_retransmission_seen),
    .o_window_update_seen  (o_window_update_seen),
    .o_pure_ack_seen       (o_pure_ack_seen),
    .o_rst_interval_added  (o_rst_interval_added)
);
